### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the RTL files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// plain invariant, also checked during reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("invariant failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### design/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared constants and types of the I2C byte master
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    // command codes carried by a request
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_RSTART = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_WRITE  = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    // register map, selected by paddr[2]
    localparam logic REG_PHASE_TICKS    = 1'b0;
    localparam logic REG_ACK_POLL_LIMIT = 1'b1;

    // register reset values
    localparam logic [7:0] PHASE_TICKS_RST    = 8'd1;
    localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd20;

    // one result per tick
    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic       status;
        logic [7:0] read_byte;
    } result_t;

endpackage

### design/i2cbm_seq.sv
// ----------------------------------------------------------------------------
// i2cbm_seq
// Bus sequencer: advances the quarter-bit state machine by one tick per request
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cbm_seq
    import i2cbm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [2:0] opcode,
    input  logic [7:0] data_byte,
    input  logic       ack_enable,
    input  logic       sda_in,
    input  logic [7:0] phase_ticks,
    input  logic [7:0] ack_poll_limit,
    output result_t    result_next
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_START  = 4'd1,
        ST_RSTART = 4'd2,
        ST_STOP   = 4'd3,
        ST_WBIT   = 4'd4,
        ST_WTAIL  = 4'd5,
        ST_RPREP  = 4'd6,
        ST_RBIT   = 4'd7,
        ST_RACK   = 4'd8
    } seq_state_t;

    typedef struct packed {
        logic scl;
        logic sda;
    } line_t;

    // line drive set on entry to a quarter
    function automatic line_t enter_quarter(seq_state_t st, logic [2:0] q,
                                            logic msb, logic ar, line_t cur);
        line_t r;
        r = cur;
        case (st)
            ST_START: begin
                if (q == 3'd0) begin
                    r.scl = 1'b1;
                    r.sda = 1'b0;
                end else if (q == 3'd1) r.sda = 1'b1;
                else r.scl = 1'b0;
            end
            ST_RSTART: begin
                if (q == 3'd0) r.sda = 1'b0;
                else if (q == 3'd1) r.scl = 1'b1;
                else if (q == 3'd2) r.sda = 1'b1;
                else r.scl = 1'b0;
            end
            ST_STOP: begin
                if (q == 3'd0) r.scl = 1'b0;
                else if (q == 3'd1) r.sda = 1'b1;
                else if (q == 3'd2) r.scl = 1'b1;
                else r.sda = 1'b0;
            end
            ST_WBIT: begin
                if (q == 3'd0) r.scl = 1'b0;
                else if (q == 3'd1) r.sda = ~msb;
                else if (q == 3'd2) r.scl = 1'b1;
            end
            ST_WTAIL: begin
                if (q == 3'd0 || q == 3'd4) r.scl = 1'b0;
                else if (q == 3'd1) r.sda = 1'b0;
                else if (q == 3'd2) r.scl = 1'b1;
            end
            ST_RPREP: begin
                if (q == 3'd0) r.scl = 1'b0;
                else r.sda = 1'b0;
            end
            ST_RBIT: begin
                if (q == 3'd0) r.scl = 1'b1;
                else if (q == 3'd2) r.scl = 1'b0;
            end
            ST_RACK: begin
                if (q == 3'd0) r.sda = ar;
                else if (q == 3'd1) r.scl = 1'b1;
                else r.scl = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    seq_state_t state_reg, state_next;
    logic [2:0] quarter_reg, quarter_next;
    logic [7:0] phase_reg, phase_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] poll_reg, poll_next;
    line_t      line_reg, line_next;
    logic       ack_flag_reg, ack_flag_next;
    logic       ack_req_reg, ack_req_next;
    logic [7:0] held_read_reg, held_read_next;

    logic       done;
    logic       advance;
    logic       finish;
    logic       go_en;
    seq_state_t go_state;
    logic [2:0] go_quarter;
    logic [7:0] span;
    logic [7:0] limit;

    // zero phase count or poll limit behaves as one
    assign span  = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    assign limit = (ack_poll_limit == 8'd0) ? 8'd1 : ack_poll_limit;

    // one tick of the sequencer
    always_comb begin
        state_next     = state_reg;
        quarter_next   = quarter_reg;
        phase_next     = phase_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        poll_next      = poll_reg;
        line_next      = line_reg;
        ack_flag_next  = ack_flag_reg;
        ack_req_next   = ack_req_reg;
        held_read_next = held_read_reg;
        done           = 1'b0;
        advance        = 1'b0;
        finish         = 1'b0;
        go_en          = 1'b0;
        go_state       = state_reg;
        go_quarter     = quarter_reg;

        // command taken only while idle
        if (step_en && state_reg == ST_IDLE &&
            (opcode inside {OP_START, OP_RSTART, OP_STOP, OP_WRITE, OP_READ})) begin
            ack_flag_next = 1'b0;
            ack_req_next  = ack_enable;
            bit_next      = 4'd0;
            poll_next     = 8'd0;
            case (opcode)
                OP_START:  state_next = ST_START;
                OP_RSTART: state_next = ST_RSTART;
                OP_STOP:   state_next = ST_STOP;
                OP_WRITE: begin
                    shift_next = data_byte;
                    state_next = ST_WBIT;
                end
                OP_READ: begin
                    shift_next = 8'd0;
                    state_next = ST_RPREP;
                end
                default: ;
            endcase
            quarter_next = 3'd0;
            phase_next   = 8'd0;
            line_next    = enter_quarter(state_next, quarter_next, shift_next[7],
                                         ack_req_next, line_next);
        end

        // phase timing, or ack polling in the high quarter of the write tail
        if (step_en && state_next != ST_IDLE) begin
            if (state_next == ST_WTAIL && quarter_next == 3'd3) begin
                if (!sda_in) begin
                    advance = 1'b1;
                end else begin
                    poll_next = 8'(poll_next + 8'd1);
                    if (poll_next >= limit) begin
                        ack_flag_next = 1'b1;
                        advance       = 1'b1;
                    end
                end
            end else begin
                phase_next = 8'(phase_next + 8'd1);
                if (phase_next >= span) begin
                    phase_next = 8'd0;
                    advance    = 1'b1;
                end
            end
        end

        // end of quarter: pick the next quarter or finish
        if (advance) begin
            case (state_next)
                ST_START: begin
                    if (quarter_next >= 3'd2) finish = 1'b1;
                    else begin
                        go_en      = 1'b1;
                        go_state   = ST_START;
                        go_quarter = 3'(quarter_next + 3'd1);
                    end
                end
                ST_RSTART, ST_STOP: begin
                    if (quarter_next >= 3'd3) finish = 1'b1;
                    else begin
                        go_en      = 1'b1;
                        go_state   = state_next;
                        go_quarter = 3'(quarter_next + 3'd1);
                    end
                end
                ST_WBIT: begin
                    go_en = 1'b1;
                    if (quarter_next < 3'd3) begin
                        go_state   = ST_WBIT;
                        go_quarter = 3'(quarter_next + 3'd1);
                    end else begin
                        shift_next = {shift_next[6:0], 1'b0};
                        bit_next   = 4'(bit_next + 4'd1);
                        go_state   = (bit_next >= 4'd8) ? ST_WTAIL : ST_WBIT;
                        go_quarter = 3'd0;
                    end
                end
                ST_WTAIL: begin
                    if (quarter_next == 3'd0 && !ack_req_next) begin
                        finish = 1'b1;
                    end else if (quarter_next >= 3'd4) begin
                        line_next.sda = 1'b1;
                        finish        = 1'b1;
                    end else begin
                        go_en      = 1'b1;
                        go_state   = ST_WTAIL;
                        go_quarter = 3'(quarter_next + 3'd1);
                    end
                end
                ST_RPREP: begin
                    go_en = 1'b1;
                    if (quarter_next == 3'd0) begin
                        go_state   = ST_RPREP;
                        go_quarter = 3'd1;
                    end else begin
                        bit_next   = 4'd0;
                        go_state   = ST_RBIT;
                        go_quarter = 3'd0;
                    end
                end
                ST_RBIT: begin
                    go_en = 1'b1;
                    // sample at the last tick of the high quarter
                    if (quarter_next == 3'd1) shift_next = {shift_next[6:0], sda_in};
                    if (quarter_next < 3'd3) begin
                        go_state   = ST_RBIT;
                        go_quarter = 3'(quarter_next + 3'd1);
                    end else begin
                        bit_next   = 4'(bit_next + 4'd1);
                        go_quarter = 3'd0;
                        if (bit_next >= 4'd8) begin
                            held_read_next = shift_next;
                            go_state       = ST_RACK;
                        end else begin
                            go_state = ST_RBIT;
                        end
                    end
                end
                ST_RACK: begin
                    if (quarter_next >= 3'd2) finish = 1'b1;
                    else begin
                        go_en      = 1'b1;
                        go_state   = ST_RACK;
                        go_quarter = 3'(quarter_next + 3'd1);
                    end
                end
                default: finish = 1'b1;
            endcase

            if (finish) begin
                state_next   = ST_IDLE;
                quarter_next = 3'd0;
                phase_next   = 8'd0;
                done         = 1'b1;
            end else if (go_en) begin
                state_next   = go_state;
                quarter_next = go_quarter;
                phase_next   = 8'd0;
                line_next    = enter_quarter(state_next, quarter_next, shift_next[7],
                                             ack_req_next, line_next);
            end
        end
    end

    // result of this tick
    assign result_next.scl_level    = line_next.scl;
    assign result_next.sda_pull_low = line_next.sda;
    assign result_next.busy_res     = (state_next != ST_IDLE);
    assign result_next.done_res     = done;
    assign result_next.status       = ack_flag_next;
    assign result_next.read_byte    = held_read_next;

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            quarter_reg   <= 3'd0;
            phase_reg     <= 8'd0;
            bit_reg       <= 4'd0;
            shift_reg     <= 8'd0;
            poll_reg      <= 8'd0;
            line_reg      <= '{scl: 1'b1, sda: 1'b0};
            ack_flag_reg  <= 1'b0;
            ack_req_reg   <= 1'b0;
            held_read_reg <= 8'd0;
        end else begin
            state_reg     <= state_next;
            quarter_reg   <= quarter_next;
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            poll_reg      <= poll_next;
            line_reg      <= line_next;
            ack_flag_reg  <= ack_flag_next;
            ack_req_reg   <= ack_req_next;
            held_read_reg <= held_read_next;
        end
    end

    // idle keeps the quarter and phase counters cleared
    `ASSERT_CLK(a_idle_counters_clear, aclk, aresetn,
        (state_reg == ST_IDLE) |-> (quarter_reg == 3'd0 && phase_reg == 8'd0))
    // a finished command leaves the sequencer idle
    `ASSERT_CLK(a_done_goes_idle, aclk, aresetn,
        (step_en && result_next.done_res) |=> (state_reg == ST_IDLE))
    // bit counter never runs past one byte
    `ASSERT_CLK(a_bit_count_range, aclk, aresetn, bit_reg <= 4'd8)
    // the write tail is the only sequence with a fifth quarter
    `ASSERT_CLK(a_quarter_range, aclk, aresetn,
        (quarter_reg == 3'd4) |-> (state_reg == ST_WTAIL))

endmodule

### design/i2c_byte_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_byte_master_unit
// Open-drain I2C master byte controller, one bus tick per request
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one timing tick: an optional command
// (start, repeated start, stop, write byte, read byte) plus the sampled SDA
// level. Each request yields exactly one result on the m_ channel: the SCL
// and SDA drive after the tick, busy, done, ack status and the last read byte.
// The result is registered at the edge that accepts its request. Throughput
// is one request per cycle unless the receiver stalls; the sequencer step is
// a single pass of logic between the state registers and the result register.
// s_ready is high whenever the result register is empty or being taken, so a
// stalled receiver holds the result and stops new requests only while it
// stalls. Commands arriving while a command runs are ignored.
// The APB port holds phase_ticks (address 0, reset 1) and ack_poll_limit
// (address 4, reset 20); write them only while the bus sequencer is idle.
// Reset (aresetn low, synchronous) empties the result register, releases SCL
// and SDA and returns the sequencer to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module i2c_byte_master_unit
    import i2cbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [7:0]  s_data_byte,
    input  logic        s_ack_enable,
    input  logic        s_sda_in,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_pull_low,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic        m_status,
    output logic [7:0]  m_read_byte,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] phase_ticks_reg;
    logic [7:0] ack_poll_limit_reg;
    logic       m_valid_reg;
    result_t    result_reg;
    result_t    result_next;
    logic       step_en;

    // configuration registers
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg    <= PHASE_TICKS_RST;
            ack_poll_limit_reg <= ACK_POLL_LIMIT_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_PHASE_TICKS:    phase_ticks_reg    <= pwdata[7:0];
                REG_ACK_POLL_LIMIT: ack_poll_limit_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register readback, low address bits ignored
    always_comb begin
        case (paddr[2])
            REG_PHASE_TICKS:    prdata = {24'd0, phase_ticks_reg};
            REG_ACK_POLL_LIMIT: prdata = {24'd0, ack_poll_limit_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // request accepted when the result slot is free or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign step_en = s_valid && s_ready;

    i2cbm_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (step_en),
        .opcode         (s_opcode),
        .data_byte      (s_data_byte),
        .ack_enable     (s_ack_enable),
        .sda_in         (s_sda_in),
        .phase_ticks    (phase_ticks_reg),
        .ack_poll_limit (ack_poll_limit_reg),
        .result_next    (result_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_scl_level    = result_reg.scl_level;
    assign m_sda_pull_low = result_reg.sda_pull_low;
    assign m_busy_res     = result_reg.busy_res;
    assign m_done_res     = result_reg.done_res;
    assign m_status       = result_reg.status;
    assign m_read_byte    = result_reg.read_byte;

endmodule
